[hdl/rthsl_pkg.sv]
// Shared constants and types for the RGB to HSL converter.
// Used by the channel interfaces, the pipelined divider, the core and its checker.
package rthsl_pkg;

   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int CHAN_WIDTH            = 8;
   // Widest divisor is twice six times the channel spread: 3060
   localparam int DEN_WIDTH             = 12;
   localparam int NUM_LANES             = 3;
   localparam int LANE_HUE              = 0;
   localparam int LANE_SAT              = 1;
   localparam int LANE_LIGHT            = 2;
   localparam int FRONT_STAGES          = 3;

   localparam logic [DEN_WIDTH-1:0] LIGHT_DEN = DEN_WIDTH'(510);

   typedef logic [CHAN_WIDTH-1:0] chan_type;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

endpackage

[hdl/rthsl_if.sv]
// Valid/ready channel interfaces for pixel requests and HSL responses.
// Depends on rthsl_pkg.
interface rthsl_req_if import rthsl_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red_in;
   chan_type green_in;
   chan_type blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rthsl_rsp_if import rthsl_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) ();
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS-1:0] hue_out;
   logic [FRACTION_BITS-1:0] saturation_out;
   logic [FRACTION_BITS-1:0] lightness_out;

   modport source (output valid, hue_out, saturation_out, lightness_out, input ready);
   modport sink   (input valid, hue_out, saturation_out, lightness_out, output ready);
endinterface

[hdl/rthsl_divider.sv]
// Three-lane restoring divider, one quotient bit per pipeline stage.
// Depends on rthsl_pkg. Quotient must be known to fit in FRACTION_BITS bits.
module rthsl_divider import rthsl_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 in_valid,
   output logic                                                 in_ready,
   input  logic [NUM_LANES-1:0][FRACTION_BITS+DEN_WIDTH-1:0]    in_dividend,
   input  logic [NUM_LANES-1:0][DEN_WIDTH-1:0]                  in_divisor,
   output logic                                                 out_valid,
   input  logic                                                 out_ready,
   output logic [NUM_LANES-1:0][FRACTION_BITS-1:0]              out_quotient
);

   localparam int FB = FRACTION_BITS;
   localparam int XW = FRACTION_BITS + DEN_WIDTH;

   typedef logic [NUM_LANES-1:0][DEN_WIDTH-1:0] den_vec_type;
   typedef logic [NUM_LANES-1:0][FB-1:0]        frac_vec_type;

   den_vec_type  rem_src [FB];
   frac_vec_type low_src [FB];
   frac_vec_type quo_src [FB];
   den_vec_type  dvs_src [FB];
   logic         vld_src [FB];

   den_vec_type  rem_in  [FB];
   frac_vec_type low_in  [FB];
   frac_vec_type quo_in  [FB];

   den_vec_type  rem_ff  [FB];
   frac_vec_type low_ff  [FB];
   frac_vec_type quo_ff  [FB];
   den_vec_type  dvs_ff  [FB];
   logic         vld_ff  [FB];

   logic         adv     [FB+1];

   assign adv[FB]      = out_ready;
   assign in_ready     = adv[0];
   assign out_valid    = vld_ff[FB-1];
   assign out_quotient = quo_ff[FB-1];

   for (genvar k = 0; k < FB; k++) begin : g_stage
      if (k == 0) begin : g_first
         // Upper dividend bits start as the partial remainder; they stay below the divisor
         always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
               rem_src[k][l] = in_dividend[l][XW-1:FB];
               low_src[k][l] = in_dividend[l][FB-1:0];
               quo_src[k][l] = '0;
               dvs_src[k][l] = in_divisor[l];
            end
         end
         assign vld_src[k] = in_valid;
      end else begin : g_next
         assign rem_src[k] = rem_ff[k-1];
         assign low_src[k] = low_ff[k-1];
         assign quo_src[k] = quo_ff[k-1];
         assign dvs_src[k] = dvs_ff[k-1];
         assign vld_src[k] = vld_ff[k-1];
      end

      assign adv[k] = !vld_ff[k] || adv[k+1];

      always_comb begin
         logic [DEN_WIDTH:0] trial;
         logic               qbit;
         for (int l = 0; l < NUM_LANES; l++) begin
            trial = {rem_src[k][l], low_src[k][l][FB-1]};
            if (trial >= {1'b0, dvs_src[k][l]}) begin
               rem_in[k][l] = DEN_WIDTH'(trial - {1'b0, dvs_src[k][l]});
               qbit         = 1'b1;
            end else begin
               rem_in[k][l] = trial[DEN_WIDTH-1:0];
               qbit         = 1'b0;
            end
            low_in[k][l] = {low_src[k][l][FB-2:0], 1'b0};
            quo_in[k][l] = {quo_src[k][l][FB-2:0], qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            vld_ff[k] <= vld_src[k];
         end
         if (adv[k] && vld_src[k]) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            dvs_ff[k] <= dvs_src[k];
         end
      end
   end

endmodule

[hdl/rgb_to_hsl_converter_core.sv]
// RGB to HSL converter core: takes one 8-bit RGB pixel per beat and returns hue,
// saturation and lightness as unsigned fractions of FRACTION_BITS bits, all ones
// meaning 1.0, each quotient rounded to nearest. A new pixel is taken every clock
// while the response side does not stall; each pixel passes through three front
// stages for max/min, sector offset and dividend setup, then one divider stage
// per quotient bit. Stages only hold when the response side stalls and
// the stage ahead is full, so bubbles are squeezed out. Depends on rthsl_pkg,
// rthsl_if and rthsl_divider.
module rgb_to_hsl_converter_core import rthsl_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rthsl_req_if.sink   req_chan,
   rthsl_rsp_if.source rsp_chan
);

   localparam int FB = FRACTION_BITS;
   localparam int XW = FRACTION_BITS + DEN_WIDTH;
   localparam logic [FB-1:0] CODE_ONE = '1;

   // Stage 1: channel extremes and sector
   chan_type   red1_ff, green1_ff, blue1_ff, max1_ff, min1_ff;
   chan_type   max1_in, min1_in;
   sector_type sector1_ff, sector1_in;
   logic       vld1_ff;

   // Stage 2: sum, spread, saturation denominator, hue offset
   logic [CHAN_WIDTH:0]   sum2_ff, sum2_in;
   chan_type              diff2_ff, diff2_in, sden2_ff, sden2_in;
   logic [DEN_WIDTH-1:0]  sixths2_ff, sixths2_in;
   logic                  vld2_ff;

   // Stage 3: dividends and divisors for the three lanes
   logic [NUM_LANES-1:0][XW-1:0]        dvd3_ff, dvd3_in;
   logic [NUM_LANES-1:0][DEN_WIDTH-1:0] dvs3_ff, dvs3_in;
   logic                                vld3_ff;

   logic adv1, adv2, adv3;
   logic div_in_ready, div_out_valid;
   logic [NUM_LANES-1:0][FB-1:0] div_quo;

   assign adv3           = !vld3_ff || div_in_ready;
   assign adv2           = !vld2_ff || adv3;
   assign adv1           = !vld1_ff || adv2;
   assign req_chan.ready = adv1;

   always_comb begin
      priority if (req_chan.red_in >= req_chan.green_in &&
                   req_chan.red_in >= req_chan.blue_in) begin
         sector1_in = SECTOR_RED;
         max1_in    = req_chan.red_in;
      end else if (req_chan.green_in >= req_chan.blue_in) begin
         sector1_in = SECTOR_GREEN;
         max1_in    = req_chan.green_in;
      end else begin
         sector1_in = SECTOR_BLUE;
         max1_in    = req_chan.blue_in;
      end
      min1_in = req_chan.red_in;
      if (req_chan.green_in < min1_in) min1_in = req_chan.green_in;
      if (req_chan.blue_in < min1_in) min1_in = req_chan.blue_in;
   end

   always_comb begin
      logic [DEN_WIDTH-1:0] d12;
      sum2_in  = {1'b0, max1_ff} + {1'b0, min1_ff};
      diff2_in = max1_ff - min1_ff;
      if (sum2_in > (CHAN_WIDTH+1)'(255)) begin
         sden2_in = CHAN_WIDTH'((CHAN_WIDTH+1)'(510) - sum2_in);
      end else begin
         sden2_in = sum2_in[CHAN_WIDTH-1:0];
      end
      d12 = DEN_WIDTH'(diff2_in);
      // Offsets wrap mod 2^DEN_WIDTH; the true value is always in [0, 6*diff) for a non-grey pixel
      unique case (sector1_ff)
         SECTOR_RED: begin
            if (green1_ff >= blue1_ff) begin
               sixths2_in = DEN_WIDTH'(green1_ff) - DEN_WIDTH'(blue1_ff);
            end else begin
               sixths2_in = (d12 << 2) + (d12 << 1) + DEN_WIDTH'(green1_ff)
                            - DEN_WIDTH'(blue1_ff);
            end
         end
         SECTOR_GREEN: sixths2_in = (d12 << 1) + DEN_WIDTH'(blue1_ff) - DEN_WIDTH'(red1_ff);
         SECTOR_BLUE:  sixths2_in = (d12 << 2) + DEN_WIDTH'(red1_ff) - DEN_WIDTH'(green1_ff);
         default:      sixths2_in = '0;
      endcase
   end

   // round(num * ONE / den) = floor((2*num*ONE + den) / (2*den)); grey maps to 0/1
   always_comb begin
      logic                                grey;
      logic [DEN_WIDTH-1:0]                d12;
      logic [NUM_LANES-1:0][DEN_WIDTH-1:0] num;
      logic [NUM_LANES-1:0][DEN_WIDTH-1:0] den;
      grey = (diff2_ff == '0);
      d12  = DEN_WIDTH'(diff2_ff);
      if (grey) begin
         num[LANE_HUE] = '0;
         den[LANE_HUE] = DEN_WIDTH'(1);
         num[LANE_SAT] = '0;
         den[LANE_SAT] = DEN_WIDTH'(1);
      end else begin
         num[LANE_HUE] = sixths2_ff;
         den[LANE_HUE] = (d12 << 2) + (d12 << 1);
         num[LANE_SAT] = d12;
         den[LANE_SAT] = DEN_WIDTH'(sden2_ff);
      end
      num[LANE_LIGHT] = DEN_WIDTH'(sum2_ff);
      den[LANE_LIGHT] = LIGHT_DEN;
      for (int l = 0; l < NUM_LANES; l++) begin
         dvd3_in[l] = (XW'(num[l]) << (FB + 1)) - (XW'(num[l]) << 1) + XW'(den[l]);
         dvs3_in[l] = den[l] << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         if (adv1) vld1_ff <= req_chan.valid;
         if (adv2) vld2_ff <= vld1_ff;
         if (adv3) vld3_ff <= vld2_ff;
      end
      if (adv1 && req_chan.valid) begin
         red1_ff    <= req_chan.red_in;
         green1_ff  <= req_chan.green_in;
         blue1_ff   <= req_chan.blue_in;
         max1_ff    <= max1_in;
         min1_ff    <= min1_in;
         sector1_ff <= sector1_in;
      end
      if (adv2 && vld1_ff) begin
         sum2_ff    <= sum2_in;
         diff2_ff   <= diff2_in;
         sden2_ff   <= sden2_in;
         sixths2_ff <= sixths2_in;
      end
      if (adv3 && vld2_ff) begin
         dvd3_ff <= dvd3_in;
         dvs3_ff <= dvs3_in;
      end
   end

   rthsl_divider #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (vld3_ff),
      .in_ready     (div_in_ready),
      .in_dividend  (dvd3_ff),
      .in_divisor   (dvs3_ff),
      .out_valid    (div_out_valid),
      .out_ready    (rsp_chan.ready),
      .out_quotient (div_quo)
   );

   // Hue that rounds up to a full turn wraps to zero
   assign rsp_chan.valid          = div_out_valid;
   assign rsp_chan.hue_out        = (div_quo[LANE_HUE] == CODE_ONE) ? '0 : div_quo[LANE_HUE];
   assign rsp_chan.saturation_out = div_quo[LANE_SAT];
   assign rsp_chan.lightness_out  = div_quo[LANE_LIGHT];

endmodule

[hdl/rthsl_checker.sv]
// Port-level checks for the RGB to HSL converter core, bound into the core module.
// Depends on rthsl_pkg and rgb_to_hsl_converter_core.
module rthsl_checker import rthsl_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [FRACTION_BITS-1:0] rsp_hue,
   input logic [FRACTION_BITS-1:0] rsp_sat,
   input logic [FRACTION_BITS-1:0] rsp_light
);

   localparam int DEPTH = FRONT_STAGES + FRACTION_BITS;
   localparam int CW    = $clog2(DEPTH + 1) + 1;

   logic [CW-1:0] cnt_ff, cnt_in;

   // Track beats inside the pipeline
   assign cnt_in = cnt_ff + CW'(req_valid && req_ready) - CW'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue) && $stable(rsp_sat)
                                  && $stable(rsp_light))
      else $error("stalled response beat changed");

   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sat == '0 |-> rsp_hue == '0)
      else $error("zero saturation with nonzero hue");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("more beats in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("response with no pixel in flight");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rgb_to_hsl_converter_core rthsl_checker #(
   .FRACTION_BITS (FRACTION_BITS)
) u_rthsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hue   (rsp_chan.hue_out),
   .rsp_sat   (rsp_chan.saturation_out),
   .rsp_light (rsp_chan.lightness_out)
);
